// ===== hw/rtl/key_whitelist_table_unit_defines.svh =====
// Assertion macros shared by the key whitelist table RTL.
// Depends on nothing; the asserting module supplies aclk and aresetn.
`ifndef KEY_WHITELIST_TABLE_UNIT_DEFINES_SVH
`define KEY_WHITELIST_TABLE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define KWT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("kwt assertion failed");
// Next-cycle implication, checked out of reset.
`define KWT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("kwt assertion failed");
`else
`define KWT_ASSERT_NOW(label, ante, cons)
`define KWT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hw/rtl/kwt_pkg.sv =====
// Package for the key whitelist table: field widths and status codes.
// No dependencies.
package kwt_pkg;

    localparam int KEY_W      = 64;
    localparam int CNT_W      = 7;
    localparam int STAT_W     = 3;
    localparam int M_TDATA_W  = 16;
    localparam int M_PAD_W    = M_TDATA_W - STAT_W - CNT_W;

    typedef logic [STAT_W-1:0] status_t;
    typedef logic [CNT_W-1:0]  count_t;

    localparam logic ACT_CHECK  = 1'b0;
    localparam logic ACT_ENROLL = 1'b1;

    localparam status_t STAT_GRANTED = 3'd0;
    localparam status_t STAT_DENIED  = 3'd1;
    localparam status_t STAT_ADDED   = 3'd2;
    localparam status_t STAT_PRESENT = 3'd3;
    localparam status_t STAT_FULL    = 3'd4;

endpackage

// ===== hw/rtl/kwt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kwt_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/key_whitelist_table_unit.sv =====
// Key whitelist table top level: sequencer, key compare and result register.
// Depends on kwt_pkg, kwt_ram and key_whitelist_table_unit_defines.svh.
//
//  channel | ports                     | contents
//  --------+---------------------------+-----------------------------------------
//  input   | s_tvalid s_tready s_tdata | tdata[63:0] key; tuser[0] action
//  result  | m_tvalid m_tready m_tdata | tdata[2:0] status, [9:3] stored_count
//
// A transaction runs idle, scan, drain, decide; an empty table skips to decide.
// In the scan the single key RAM read port delivers one stored entry per cycle
// to the shared 64-bit comparator. s_tready is high only while the sequencer
// idles. A finished result waits in the output register; the sequencer holds
// in its decide step until that register is free. aresetn (synchronous)
// empties the table by clearing the count; the key RAM itself is never cleared.
`include "key_whitelist_table_unit_defines.svh"
module key_whitelist_table_unit
    import kwt_pkg::*;
#(
    parameter int MAX_KEYS = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [KEY_W-1:0]     s_tdata,   // [63:0] key
    input  logic [0:0]           s_tuser,   // [0] action
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [2:0] status, [9:3] stored_count
);

    localparam int ADDR_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_DECIDE = 2'd3;

    localparam count_t MAX_CNT = CNT_W'(MAX_KEYS);

    logic [1:0]        state_reg, state_next;
    count_t            count_reg, count_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic              cmp_pend_reg, cmp_pend_next;
    logic              hit_reg, hit_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic              act_reg, act_next;
    logic              m_valid_reg, m_valid_next;
    status_t           m_status_reg, m_status_next;
    count_t            m_count_reg, m_count_next;

    logic              rd_en;
    logic [KEY_W-1:0]  rd_data;
    logic              wr_en;
    logic              out_load;
    status_t           status_calc;

    kwt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_KEYS)
    ) u_key_ram (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (key_reg),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    // Result of the search, valid in the decide step.
    always_comb begin
        if (act_reg == ACT_CHECK) begin
            status_calc = hit_reg ? STAT_GRANTED : STAT_DENIED;
        end else if (hit_reg) begin
            status_calc = STAT_PRESENT;
        end else if (count_reg >= MAX_CNT) begin
            status_calc = STAT_FULL;
        end else begin
            status_calc = STAT_ADDED;
        end
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        key_next      = key_reg;
        act_next      = act_reg;
        m_status_next = m_status_reg;
        m_count_next  = m_count_reg;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        out_load      = 1'b0;

        // Compare the entry read in the previous cycle.
        hit_next = hit_reg | (cmp_pend_reg && (rd_data == key_reg));

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    key_next   = s_tdata;
                    act_next   = s_tuser[0];
                    idx_next   = '0;
                    hit_next   = 1'b0;
                    // Skip the scan when nothing is stored.
                    state_next = (count_reg == '0) ? S_DECIDE : S_SCAN;
                end
            end
            S_SCAN: begin
                rd_en    = 1'b1;
                idx_next = idx_reg + ADDR_W'(1);
                if (CNT_W'(idx_reg) == count_reg - CNT_W'(1)) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // Let the last read reach the comparator.
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (!m_valid_reg || m_tready) begin
                    out_load = 1'b1;
                    if (status_calc == STAT_ADDED) begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    m_status_next = status_calc;
                    m_count_next  = (status_calc == STAT_ADDED) ?
                                    count_reg + CNT_W'(1) : count_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        cmp_pend_next = rd_en;

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            cmp_pend_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            cmp_pend_reg <= cmp_pend_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload and search scratch: no reset needed.
    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        hit_reg      <= hit_next;
        key_reg      <= key_next;
        act_reg      <= act_next;
        m_status_reg <= m_status_next;
        m_count_reg  <= m_count_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_count_reg, m_status_reg};

    // Never hold more keys than the table has rows.
    `KWT_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= MAX_CNT)
    // An added key grows the count by exactly one.
    `KWT_ASSERT_NEXT(a_add_grows, out_load && (status_calc == STAT_ADDED), count_reg == $past(count_reg) + CNT_W'(1))
    // A check never reports an enroll status.
    `KWT_ASSERT_NOW(a_check_status, out_load && (act_reg == ACT_CHECK), (status_calc == STAT_GRANTED) || (status_calc == STAT_DENIED))

endmodule

// ===== bench/tb_key_whitelist_table_unit.sv =====
// Self-checking testbench for key_whitelist_table_unit: checks and enrolls keys
// through the stream ports and compares every result with an in-bench table model.
// Depends on kwt_pkg and the key_whitelist_table_unit RTL.
`timescale 1ns / 1ps

module tb_key_whitelist_table_unit
    import kwt_pkg::*;
();

    localparam int  TABLE_DEPTH  = 64;
    localparam int  CLK_HALF     = 6;
    localparam int  RESET_CYCLES = 10;
    localparam int  RANDOM_ITEMS = 1330;
    localparam int  HOLD_CYCLES  = 300;
    localparam int  DRAIN_CYCLES = 100;
    localparam int  PRINT_CAP    = 50;
    localparam int  PAD_LSB      = STAT_W + CNT_W;
    localparam logic [KEY_W-1:0] ALL_ONES = {KEY_W{1'b1}};

    // One key request as it travels on the input channel.
    typedef struct packed {
        logic             action;
        logic [KEY_W-1:0] key;
    } key_request_t;

    // The verdict the table owes for one request.
    typedef struct packed {
        status_t status;
        count_t  count;
    } verdict_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [KEY_W-1:0]     s_tdata  = '0;   // [63:0] key
    logic [0:0]           s_tuser  = '0;   // [0] action
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // [2:0] status, [9:3] stored_count, rest zero

    key_request_t     key_requests[$];     // requests waiting for the driver
    verdict_t         owed_verdicts[$];    // verdicts of accepted requests, oldest first
    logic [KEY_W-1:0] offered_keys[$];     // every key ever sent for enrollment

    // Mirror of the table contents as the block should hold them.
    logic [KEY_W-1:0] mirror_keys[TABLE_DEPTH];
    int unsigned      mirror_count = 0;

    logic        s_fire      = 1'b0;   // request taken at the last rising edge
    logic        idle_on     = 1'b1;
    logic        hold_off    = 1'b0;
    int unsigned s_gap       = 0;
    int unsigned m_stall     = 0;
    int unsigned accepted    = 0;
    int unsigned delivered   = 0;
    int unsigned mismatches  = 0;
    int unsigned status_seen[5] = '{default: 0};

    key_whitelist_table_unit #(
        .MAX_KEYS (TABLE_DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // Search the mirror for the key, then grant, deny, append or refuse.
    // Enrollment tests presence before fullness, so a stored key in a full
    // table still reads as already present.
    function automatic verdict_t lookup_and_enroll(input key_request_t req);
        verdict_t    v;
        logic        hit;
        int unsigned i;
        hit = 1'b0;
        for (i = 0; i < mirror_count; i++) begin
            if (mirror_keys[i] == req.key) begin
                hit = 1'b1;
            end
        end
        if (req.action == ACT_CHECK) begin
            v.status = hit ? STAT_GRANTED : STAT_DENIED;
        end else if (hit) begin
            v.status = STAT_PRESENT;
        end else if (mirror_count >= TABLE_DEPTH) begin
            v.status = STAT_FULL;
        end else begin
            mirror_keys[mirror_count] = req.key;
            mirror_count++;
            v.status = STAT_ADDED;
        end
        v.count = count_t'(mirror_count);
        return v;
    endfunction

    task automatic report_mismatch(input string what, input logic [KEY_W-1:0] got,
                                   input logic [KEY_W-1:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP) begin
            $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        end
    endtask

    // Queue one request; remember enrolled keys so later items can reuse them.
    task automatic queue_request(input logic action, input logic [KEY_W-1:0] key);
        key_requests.push_back('{action: action, key: key});
        if (action == ACT_ENROLL) begin
            offered_keys.push_back(key);
        end
    endtask

    // Pick a key: mostly known ones, some with a single bit flipped to
    // exercise the comparator, the rest fresh.
    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        int unsigned      kind;
        kind = $urandom_range(0, 9);
        if (offered_keys.size() == 0 || kind >= 7) begin
            k = {$urandom, $urandom};
        end else begin
            k = offered_keys[$urandom_range(0, offered_keys.size() - 1)];
            if (kind >= 5) begin
                k[$urandom_range(0, KEY_W - 1)] ^= 1'b1;
            end
        end
        return k;
    endfunction

    // Input driver: change at the falling edge; advance only after the
    // current transaction was taken, with random gaps between items.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_fire) begin
            if (s_gap > 0) begin
                s_gap--;
                s_tvalid <= 1'b0;
            end else if (key_requests.size() > 0) begin
                key_request_t req;
                req = key_requests.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= req.key;
                s_tuser  <= req.action;
                if (idle_on && $urandom_range(0, 3) == 0) begin
                    s_gap = $urandom_range(1, 10);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result ready driver: random stall bursts, plus the long hold-off.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (m_stall > 0) begin
            m_stall--;
            m_tready <= 1'b0;
        end else if (hold_off) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 5) == 0) begin
                m_stall = $urandom_range(1, 10);
            end
        end
    end

    // Monitor: sample both channels at the rising edge. Predict on every
    // accepted request and compare every delivered result with the oldest
    // owed verdict.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_fire <= 1'b0;
        end else begin
            s_fire <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                owed_verdicts.push_back(lookup_and_enroll('{action: s_tuser[0], key: s_tdata}));
                accepted++;
            end
            if (m_tvalid && m_tready) begin
                delivered++;
                if (owed_verdicts.size() == 0) begin
                    report_mismatch("unexpected result", KEY_W'(m_tdata), '0);
                end else begin
                    verdict_t v;
                    v = owed_verdicts.pop_front();
                    if (m_tdata[STAT_W-1:0] != v.status) begin
                        report_mismatch("status", KEY_W'(m_tdata[STAT_W-1:0]),
                                        KEY_W'(v.status));
                    end
                    if (m_tdata[PAD_LSB-1:STAT_W] != v.count) begin
                        report_mismatch("stored_count", KEY_W'(m_tdata[PAD_LSB-1:STAT_W]),
                                        KEY_W'(v.count));
                    end
                    if (m_tdata[M_TDATA_W-1:PAD_LSB] != '0) begin
                        report_mismatch("padding", KEY_W'(m_tdata[M_TDATA_W-1:PAD_LSB]), '0);
                    end
                    if (v.status <= STAT_FULL) begin
                        status_seen[v.status]++;
                    end
                end
            end
        end
    end

    // Long receiver hold-off in mid-run: the result register stays occupied,
    // the sequencer stalls and the sender keeps offering its next request.
    initial begin
        wait (accepted >= 200);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #(1_000_000 * 2 * CLK_HALF);
        $display("FAILURE");
        $finish;
    end

    // Stimulus and end of run.
    initial begin
        int unsigned n;
        logic        act;

        // Directed: empty-table checks, key extremes, duplicates, near misses.
        queue_request(ACT_CHECK,  '0);
        queue_request(ACT_CHECK,  ALL_ONES);
        queue_request(ACT_ENROLL, '0);
        queue_request(ACT_CHECK,  '0);
        queue_request(ACT_CHECK,  ALL_ONES);
        queue_request(ACT_ENROLL, ALL_ONES);
        queue_request(ACT_ENROLL, '0);
        queue_request(ACT_ENROLL, ALL_ONES);
        queue_request(ACT_CHECK,  ALL_ONES);
        queue_request(ACT_CHECK,  64'h0000_0000_0000_0001);
        queue_request(ACT_CHECK,  64'h7FFF_FFFF_FFFF_FFFF);
        queue_request(ACT_ENROLL, 64'hAAAA_AAAA_AAAA_AAAA);
        queue_request(ACT_ENROLL, 64'h5555_5555_5555_5555);
        queue_request(ACT_CHECK,  64'hAAAA_AAAA_AAAA_AAAA);
        queue_request(ACT_CHECK,  64'h5555_5555_5555_5555);
        queue_request(ACT_CHECK,  64'h8000_0000_0000_0000);
        queue_request(ACT_ENROLL, 64'h8000_0000_0000_0000);
        queue_request(ACT_CHECK,  64'h8000_0000_0000_0000);
        queue_request(ACT_CHECK,  64'hAAAA_AAAA_AAAA_AAAB);

        // Random: about a third enrolls, so the table fills early and the
        // larger part of the run works against a full table.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            act = ($urandom_range(0, 99) < 35) ? ACT_ENROLL : ACT_CHECK;
            queue_request(act, pick_key());
        end

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // Drop all idling for the tail of the run.
        wait (key_requests.size() < 100);
        @(posedge aclk);
        idle_on = 1'b0;

        while (key_requests.size() != 0 || s_tvalid || owed_verdicts.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d key transactions: %0d granted, %0d denied, %0d added, %0d present, %0d full",
                 delivered, status_seen[STAT_GRANTED], status_seen[STAT_DENIED],
                 status_seen[STAT_ADDED], status_seen[STAT_PRESENT], status_seen[STAT_FULL]);
        $display("Table ended with %0d of %0d keys; %0d mismatches",
                 mirror_count, TABLE_DEPTH, mismatches);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
